@@ hw/rtl/bpa_pkg.sv @@
// Package for the bitmap page allocator: sizes, codes, interface structs and
// the mask and bit-search helpers shared by the controller. No dependencies.
package bpa_pkg;

  localparam int unsigned MaxPages  = 32768;
  localparam int unsigned WordCount = (MaxPages + 31) / 32;
  localparam int unsigned WordAw    = $clog2(WordCount);
  localparam int unsigned WordsW    = $clog2(WordCount + 1);
  localparam int unsigned PagesW    = $clog2(MaxPages + 1);
  localparam int unsigned PageIdxW  = WordAw + 5;

  localparam logic [31:0] PageMask  = 32'h0000_0FFF;
  localparam logic [31:0] PageBytes = 32'h0000_1000;

  localparam logic CfgRegionBase = 1'b0;
  localparam logic CfgRegionSize = 1'b1;

  typedef enum logic [1:0] {
    ModeAlloc = 2'd0,
    ModeFree  = 2'd1,
    ModeInit  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    StatusOk          = 3'd0,
    StatusNoFree      = 3'd1,
    StatusOutOfRange  = 3'd2,
    StatusAlreadyFree = 3'd3,
    StatusNoInit      = 3'd4
  } status_e;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [WordAw-1:0] addr;
    logic [31:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    status_e     status;
  } res_t;

  // Bits of word w that lie below the page count cnt.
  function automatic logic [31:0] count_mask(logic [WordAw-1:0] w, logic [PagesW-1:0] cnt);
    logic [31:0] first;
    logic [31:0] left;
    logic [31:0] r;
    first = 32'({w, 5'b00000});
    left  = 32'(cnt) - first;
    if (first >= 32'(cnt)) begin
      r = 32'd0;
    end else if (left >= 32'd32) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = (32'd1 << left[4:0]) - 32'd1;
    end
    return r;
  endfunction

  function automatic logic [4:0] lowest_bit(logic [31:0] v);
    logic [4:0] r;
    r = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/bitmap_page_allocator_top.sv @@
// Top level of the bitmap page allocator: configuration registers, bitmap
// RAM, controller and result register. Uses bpa_pkg, bpa_ram and bpa_ctrl.
//
//   Channel   Direction  Handshake              Word
//   command   in         start_i && !busy_o     mode_i, free_address_i
//   result    out        done_o (one cycle)     page_address_o, status_o
//   config    in         cfg_we_i               cfg_addr_i, cfg_wdata_i
//
// Results appear in the cycle after the controller ends; the receiver cannot stall.
// Unused mode and refused items are answered from idle. Free checks the range,
// then reads the bitmap word and clears the page bit. Allocate reads words from
// the hint on, wrapping, and sets the lowest free bit found, else reports none free.
// Init sets up the region, then the RAM port sweeps each bitmap word, up to 1024.
// Reset clears control state only; the bitmap is not read before an init sweeps it.
module bitmap_page_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] free_address_i,
  output logic        done_o,
  output logic [31:0] page_address_o,
  output logic [2:0]  status_o,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);
  import bpa_pkg::*;

  logic [31:0] region_base_q;
  logic [31:0] region_size_q;
  logic        done_q;
  logic [31:0] addr_q;
  logic [2:0]  status_q;
  logic        busy;
  mem_req_t    mem_req;
  logic [31:0] mem_rdata;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
      region_size_q <= '0;
      done_q        <= 1'b0;
    end else begin
      done_q <= res.valid;
      if (cfg_we_i && cfg_addr_i == CfgRegionBase) begin
        region_base_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_addr_i == CfgRegionSize) begin
        region_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      addr_q   <= res.addr;
      status_q <= res.status;
    end
  end

  bpa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i        (start_i && !busy),
    .mode_i,
    .free_address_i,
    .region_base_i  (region_base_q),
    .region_size_i  (region_size_q),
    .mem_rdata_i    (mem_rdata),
    .busy_o         (busy),
    .mem_o          (mem_req),
    .res_o          (res)
  );

  bpa_ram #(
    .Depth (WordCount),
    .Width (32)
  ) u_ram (
    .clk_i,
    .re_i    (mem_req.re),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  assign busy_o         = busy;
  assign done_o         = done_q;
  assign page_address_o = addr_q;
  assign status_o       = status_q;

endmodule

@@ hw/rtl/bpa_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
// Controller of the bitmap page allocator: region setup, bitmap sweep, word
// search and bit updates. Uses bpa_pkg; drives the bitmap RAM port.
module bpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          mode_i,
  input  logic [31:0]         free_address_i,
  input  logic [31:0]         region_base_i,
  input  logic [31:0]         region_size_i,
  input  logic [31:0]         mem_rdata_i,
  output logic                busy_o,
  output bpa_pkg::mem_req_t   mem_o,
  output bpa_pkg::res_t       res_o
);
  import bpa_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StInit0 = 4'd1;
  localparam logic [3:0] StInit1 = 4'd2;
  localparam logic [3:0] StInit2 = 4'd3;
  localparam logic [3:0] StClear = 4'd4;
  localparam logic [3:0] StSrch  = 4'd5;
  localparam logic [3:0] StAwr   = 4'd6;
  localparam logic [3:0] StFree0 = 4'd7;
  localparam logic [3:0] StFree1 = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [31:0]       start_q, start_d;
  logic [31:0]       end_q, end_d;
  logic [PagesW-1:0] pages_q, pages_d;
  logic [WordsW-1:0] words_q, words_d;
  logic [WordAw-1:0] hint_q, hint_d;
  logic              init_q, init_d;
  logic [PagesW-1:0] bmp_q, bmp_d;
  logic [WordAw-1:0] rd_w_q, rd_w_d;
  logic [WordsW-1:0] iss_q, iss_d;
  logic              dv_q, dv_d;
  logic [WordAw-1:0] dw_q, dw_d;
  logic              dlast_q, dlast_d;
  logic [WordAw-1:0] fw_q, fw_d;
  logic [4:0]        fbit_q, fbit_d;
  logic [31:0]       fword_q, fword_d;
  logic [31:0]       faddr_q, faddr_d;

  logic [31:0] diff;
  logic [19:0] pg;
  logic [31:0] words_t;
  logic [31:0] bmp_t;
  logic [31:0] free_bits;
  logic [31:0] offs;
  logic [19:0] idx;

  always_comb begin
    state_d = state_q;
    start_d = start_q;
    end_d   = end_q;
    pages_d = pages_q;
    words_d = words_q;
    hint_d  = hint_q;
    init_d  = init_q;
    bmp_d   = bmp_q;
    rd_w_d  = rd_w_q;
    iss_d   = iss_q;
    dv_d    = 1'b0;
    dw_d    = dw_q;
    dlast_d = dlast_q;
    fw_d    = fw_q;
    fbit_d  = fbit_q;
    fword_d = fword_q;
    faddr_d = faddr_q;
    mem_o   = '0;
    res_o   = '{valid: 1'b0, addr: 32'd0, status: StatusOk};

    diff      = end_q - start_q;
    pg        = diff[31:12];
    words_t   = (32'(pages_q) + 32'd31) >> 5;
    bmp_t     = ((words_t << 2) + PageMask) >> 12;
    free_bits = ~mem_rdata_i & count_mask(dw_q, pages_q);
    offs      = faddr_q - start_q;
    idx       = offs[31:12];

    case (state_q)
      StIdle: begin
        if (start_i) begin
          case (mode_e'(mode_i))
            ModeInit: begin
              state_d = StInit0;
            end
            ModeAlloc: begin
              if (!init_q) begin
                res_o.valid  = 1'b1;
                res_o.status = StatusNoInit;
              end else if (words_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.status = StatusNoFree;
              end else begin
                rd_w_d  = hint_q;
                iss_d   = '0;
                state_d = StSrch;
              end
            end
            ModeFree: begin
              if (!init_q) begin
                res_o.valid  = 1'b1;
                res_o.status = StatusNoInit;
              end else begin
                faddr_d = free_address_i;
                state_d = StFree0;
              end
            end
            default: begin
              res_o.valid = 1'b1;
            end
          endcase
        end
      end
      StInit0: begin
        start_d = (region_base_i + PageMask) & ~PageMask;
        end_d   = (region_base_i + region_size_i) & ~PageMask;
        state_d = StInit1;
      end
      StInit1: begin
        if (end_q > start_q) begin
          if (32'(pg) > 32'(MaxPages)) begin
            pages_d = PagesW'(MaxPages);
            end_d   = start_q + (32'(MaxPages) << 12);
          end else begin
            pages_d = PagesW'(pg);
          end
        end else begin
          pages_d = '0;
          end_d   = start_q;
        end
        state_d = StInit2;
      end
      StInit2: begin
        if (bmp_t > 32'(pages_q)) begin
          bmp_t = 32'(pages_q);
        end
        words_d = WordsW'(words_t);
        bmp_d   = PagesW'(bmp_t);
        hint_d  = WordAw'(bmp_t >> 5);
        rd_w_d  = '0;
        if (words_t == 32'd0) begin
          init_d      = 1'b1;
          res_o.valid = 1'b1;
          state_d     = StIdle;
        end else begin
          state_d = StClear;
        end
      end
      StClear: begin
        mem_o.we    = 1'b1;
        mem_o.addr  = rd_w_q;
        mem_o.wdata = count_mask(rd_w_q, bmp_q);
        if (WordsW'(rd_w_q) + WordsW'(1) == words_q) begin
          init_d      = 1'b1;
          res_o.valid = 1'b1;
          state_d     = StIdle;
        end else begin
          rd_w_d = rd_w_q + WordAw'(1);
        end
      end
      StSrch: begin
        if (dv_q && free_bits != 32'd0) begin
          fw_d    = dw_q;
          fbit_d  = lowest_bit(free_bits);
          fword_d = mem_rdata_i;
          state_d = StAwr;
        end else if (dv_q && dlast_q) begin
          res_o.valid  = 1'b1;
          res_o.status = StatusNoFree;
          state_d      = StIdle;
        end else if (iss_q < words_q) begin
          mem_o.re   = 1'b1;
          mem_o.addr = rd_w_q;
          dv_d       = 1'b1;
          dw_d       = rd_w_q;
          dlast_d    = (iss_q + WordsW'(1) == words_q);
          iss_d      = iss_q + WordsW'(1);
          if (WordsW'(rd_w_q) + WordsW'(1) == words_q) begin
            rd_w_d = '0;
          end else begin
            rd_w_d = rd_w_q + WordAw'(1);
          end
        end
      end
      StAwr: begin
        mem_o.we    = 1'b1;
        mem_o.addr  = fw_q;
        mem_o.wdata = fword_q | (32'd1 << fbit_q);
        hint_d      = fw_q;
        res_o.valid = 1'b1;
        res_o.addr  = start_q + 32'({fw_q, fbit_q, 12'h000});
        state_d     = StIdle;
      end
      StFree0: begin
        if (faddr_q < start_q || faddr_q >= end_q) begin
          res_o.valid  = 1'b1;
          res_o.status = StatusOutOfRange;
          state_d      = StIdle;
        end else if (32'(idx) >= 32'(MaxPages)) begin
          res_o.valid  = 1'b1;
          res_o.status = StatusAlreadyFree;
          state_d      = StIdle;
        end else begin
          mem_o.re   = 1'b1;
          mem_o.addr = idx[PageIdxW-1:5];
          fw_d       = idx[PageIdxW-1:5];
          fbit_d     = idx[4:0];
          state_d    = StFree1;
        end
      end
      StFree1: begin
        res_o.valid = 1'b1;
        state_d     = StIdle;
        if (!mem_rdata_i[fbit_q]) begin
          res_o.status = StatusAlreadyFree;
        end else begin
          mem_o.we    = 1'b1;
          mem_o.addr  = fw_q;
          mem_o.wdata = mem_rdata_i & ~(32'd1 << fbit_q);
          if (fw_q < hint_q) begin
            hint_d = fw_q;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      start_q <= '0;
      end_q   <= '0;
      pages_q <= '0;
      words_q <= '0;
      hint_q  <= '0;
      init_q  <= 1'b0;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      end_q   <= end_d;
      pages_q <= pages_d;
      words_q <= words_d;
      hint_q  <= hint_d;
      init_q  <= init_d;
      dv_q    <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bmp_q   <= bmp_d;
    rd_w_q  <= rd_w_d;
    iss_q   <= iss_d;
    dw_q    <= dw_d;
    dlast_q <= dlast_d;
    fw_q    <= fw_d;
    fbit_q  <= fbit_d;
    fword_q <= fword_d;
    faddr_q <= faddr_d;
  end

endmodule

@@ hw/rtl/bpa_checker.sv @@
// Port-level checker for the bitmap page allocator and its bind to the top.
// Uses bpa_pkg and observes bitmap_page_allocator_top ports only.
module bpa_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [31:0] page_address_o,
  input logic [2:0]  status_o
);
  import bpa_pkg::*;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("Result word shown while busy.");

  a_accept_reacts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("Accepted word caused neither work nor a result.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StatusOk) |-> (page_address_o == 32'd0))
    else $error("Failed result word carries an address.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= StatusNoInit))
    else $error("Result word carries an unknown status.");

endmodule

bind bitmap_page_allocator_top bpa_port_checker u_bpa_port_checker (
  .clk_i,
  .rst_ni,
  .start_i,
  .busy_o,
  .done_o,
  .page_address_o,
  .status_o
);

@@ bench/bpa_checker.sv @@
// Result checker for the bitmap page allocator: follows the command, config
// and result channels, predicts every result word and compares it.
// Depends on bpa_pkg for sizes, mode and status codes.
module bpa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [31:0] free_address_i,
  input  logic        done_i,
  input  logic [31:0] page_address_i,
  input  logic [2:0]  status_i,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  output int          errors_o,
  output int          backlog_o,
  output int          checked_o,
  output int          exhausted_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  typedef struct packed {
    logic [31:0] addr;
    status_e     status;
  } reply_t;

  logic [31:0] region_base_q;
  logic [31:0] region_size_q;
  logic [31:0] page_map [WordCount];
  logic [31:0] span_start;
  logic [31:0] span_end;
  int unsigned span_pages;
  int unsigned span_words;
  int unsigned hint_word;
  bit          ready;
  reply_t      pending_replies [$];

  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s: expected %08h, got %08h", $time, what, want, got);
    errors_o++;
  endtask

  function automatic logic [31:0] real_pages(int unsigned w);
    int unsigned first;
    first = w * 32;
    if (first >= span_pages) return '0;
    if (span_pages - first >= 32) return '1;
    return (32'd1 << (span_pages - first)) - 32'd1;
  endfunction

  function automatic void region_init();
    logic [31:0] lo;
    logic [31:0] hi;
    int unsigned own;
    lo = (region_base_q + PageMask) & ~PageMask;
    hi = (region_base_q + region_size_q) & ~PageMask;
    span_pages = 0;
    if (hi > lo) begin
      span_pages = (hi - lo) >> 12;
      if (span_pages > MaxPages) begin
        span_pages = MaxPages;
        hi = lo + MaxPages * PageBytes;
      end
    end else begin
      hi = lo;
    end
    span_start = lo;
    span_end   = hi;
    span_words = (span_pages + 31) / 32;
    foreach (page_map[i]) page_map[i] = '0;
    // The bitmap itself is taken to live in the first pages of the region.
    own = (span_words * 4 + PageMask) / PageBytes;
    if (own > span_pages) own = span_pages;
    for (int unsigned i = 0; i < own; i++) page_map[i >> 5][i % 32] = 1'b1;
    hint_word = own >> 5;
    ready = 1'b1;
  endfunction

  function automatic bit take_from(int unsigned w, output reply_t r);
    logic [31:0] open_bits;
    int unsigned b;
    r = '0;
    if (w >= WordCount) return 1'b0;
    open_bits = ~page_map[w] & real_pages(w);
    if (open_bits == '0) return 1'b0;
    b = 0;
    while (!open_bits[b]) b++;
    page_map[w][b] = 1'b1;
    hint_word = w;
    r.addr   = span_start + (w * 32 + b) * PageBytes;
    r.status = StatusOk;
    return 1'b1;
  endfunction

  function automatic reply_t page_alloc();
    reply_t r;
    r = '{addr: '0, status: StatusNoFree};
    if (!ready) begin
      r.status = StatusNoInit;
      return r;
    end
    for (int unsigned w = hint_word; w < span_words; w++) begin
      if (take_from(w, r)) return r;
    end
    for (int unsigned w = 0; w < hint_word && w < span_words; w++) begin
      if (take_from(w, r)) return r;
    end
    return '{addr: '0, status: StatusNoFree};
  endfunction

  function automatic status_e page_free(logic [31:0] a);
    int unsigned idx;
    int unsigned w;
    if (!ready) return StatusNoInit;
    if (a < span_start || a >= span_end) return StatusOutOfRange;
    idx = (a - span_start) >> 12;
    w = idx >> 5;
    if (w >= WordCount || !page_map[w][idx % 32]) return StatusAlreadyFree;
    page_map[w][idx % 32] = 1'b0;
    if (w < hint_word) hint_word = w;
    return StatusOk;
  endfunction

  function automatic reply_t next_reply(logic [1:0] m, logic [31:0] a);
    reply_t r;
    r = '{addr: '0, status: StatusOk};
    case (m)
      ModeAlloc: r = page_alloc();
      ModeFree:  r.status = page_free(a);
      ModeInit:  region_init();
      default:   ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      region_base_q = '0;
      region_size_q = '0;
      span_start    = '0;
      span_end      = '0;
      span_pages    = 0;
      span_words    = 0;
      hint_word     = 0;
      ready         = 1'b0;
      pending_replies.delete();
      errors_o      = 0;
      backlog_o     = 0;
      checked_o     = 0;
      exhausted_o   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CfgRegionBase) region_base_q = cfg_wdata_i;
        else region_size_q = cfg_wdata_i;
      end
      if (done_i) begin
        if (pending_replies.size() == 0) begin
          flag("result word with nothing outstanding, page_address", '0, page_address_i);
        end else begin
          want = pending_replies.pop_front();
          checked_o++;
          if (want.status == StatusNoFree) exhausted_o++;
          if (page_address_i !== want.addr) flag("page_address", want.addr, page_address_i);
          if (status_i !== want.status) flag("status", 32'(want.status), 32'(status_i));
        end
      end
      if (start_i && !busy_i) pending_replies.push_back(next_reply(mode_i, free_address_i));
      backlog_o = pending_replies.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// Top of the bitmap page allocator bench: directed and random command words over
// many region settings, with random sender gaps. Results are checked by bpa_checker.
// Depends on bpa_pkg, bpa_checker and bitmap_page_allocator_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam logic [1:0]  ModeUnused  = 2'd3;
  localparam int unsigned RandomItems = 1950;
  localparam int unsigned CycleLimit  = 10_000_000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic        busy_o;
  logic [1:0]  mode_i         = ModeAlloc;
  logic [31:0] free_address_i = '0;
  logic        done_o;
  logic [31:0] page_address_o;
  logic [2:0]  status_o;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_addr_i     = CfgRegionBase;
  logic [31:0] cfg_wdata_i    = '0;

  int          errors;
  int          backlog;
  int          checked;
  int          exhausted;

  logic [31:0] win_start;
  int unsigned win_pages;
  int unsigned alloc_share;
  bit          no_gaps;
  int unsigned sent;
  int unsigned n_alloc;
  int unsigned n_free;
  int unsigned n_init;
  int unsigned n_other;
  int unsigned region_count;
  int unsigned cycles;

  always #5 clk_i = ~clk_i;

  bitmap_page_allocator_top DUT (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .mode_i,
    .free_address_i,
    .done_o,
    .page_address_o,
    .status_o,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i
  );

  bpa_checker u_check (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i         (busy_o),
    .mode_i,
    .free_address_i,
    .done_i         (done_o),
    .page_address_i (page_address_o),
    .status_i       (status_o),
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .errors_o       (errors),
    .backlog_o      (backlog),
    .checked_o      (checked),
    .exhausted_o    (exhausted)
  );

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic issue(input logic [1:0] m, input logic [31:0] a);
    int unsigned gap;
    start_i        <= 1'b1;
    mode_i         <= m;
    free_address_i <= a;
    do @(posedge clk_i); while (busy_o);
    sent++;
    case (m)
      ModeAlloc: n_alloc++;
      ModeFree:  n_free++;
      ModeInit:  n_init++;
      default:   n_other++;
    endcase
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (backlog != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] base, input logic [31:0] size);
    logic [31:0] lo;
    logic [31:0] hi;
    settle();
    write_reg(CfgRegionBase, base);
    write_reg(CfgRegionSize, size);
    lo = (base + PageMask) & ~PageMask;
    hi = (base + size) & ~PageMask;
    win_start = lo;
    win_pages = 0;
    if (hi > lo) win_pages = ((hi - lo) >> 12) > MaxPages ? MaxPages : (hi - lo) >> 12;
    region_count++;
  endtask

  task automatic random_word();
    int unsigned pick;
    logic [31:0] a;
    pick = $urandom_range(0, 99);
    a = $urandom;
    if (pick < alloc_share) begin
      issue(ModeAlloc, a);
    end else if (pick < 88) begin
      if (win_pages != 0) begin
        a = win_start + $urandom_range(0, win_pages - 1) * PageBytes
            + $urandom_range(0, PageMask);
      end
      issue(ModeFree, a);
    end else if (pick < 93) begin
      case ($urandom_range(0, 2))
        0:       a = win_start - 1;
        1:       a = win_start + win_pages * PageBytes;
        default: ;
      endcase
      issue(ModeFree, a);
    end else if (pick < 96) begin
      issue(ModeInit, a);
    end else begin
      issue(ModeUnused, a);
    end
    if ($urandom_range(0, 99) == 0) settle();
  endtask

  initial begin
    int unsigned directed;
    int unsigned len;
    logic [31:0] base;
    logic [31:0] size;
    sent = 0;
    n_alloc = 0;
    n_free = 0;
    n_init = 0;
    n_other = 0;
    region_count = 0;
    no_gaps = 1'b0;
    win_start = '0;
    win_pages = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before init, then an empty region from the reset register values.
    issue(ModeAlloc, '1);
    issue(ModeFree, 32'h0000_1000);
    issue(ModeUnused, 32'hA5A5_5A5A);
    issue(ModeInit, '0);
    issue(ModeAlloc, '0);
    issue(ModeFree, '0);

    // The aligned base wraps to zero; 39 pages leave padding in the last word.
    configure(32'hFFFF_F001, 32'h0002_8000);
    issue(ModeInit, '0);
    issue(ModeAlloc, '0);
    issue(ModeAlloc, '0);
    issue(ModeAlloc, '0);
    issue(ModeFree, 32'h0000_0000);
    issue(ModeFree, 32'h0000_0000);
    issue(ModeFree, 32'h0002_7000);
    issue(ModeFree, 32'hFFFF_FFFF);
    issue(ModeFree, 32'h0000_1FFF);
    issue(ModeAlloc, '0);
    issue(ModeUnused, '1);

    // A region far above the page limit saturates.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(ModeInit, '1);
    issue(ModeAlloc, '0);
    issue(ModeFree, 32'h07FF_F000);
    issue(ModeFree, 32'h0800_0000);

    // The aligned end falls below the aligned start.
    configure(32'h1234_5FFF, 32'h0000_0000);
    issue(ModeInit, '0);
    issue(ModeAlloc, '0);
    directed = sent;

    while (sent < directed + RandomItems) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          base = $urandom;
          size = $urandom_range(100, 3000) * PageBytes + $urandom_range(0, PageMask);
          len  = $urandom_range(20, 80);
        end
        9: begin
          if ($urandom_range(0, 1) == 0) begin
            base = $urandom_range(0, 32'h7FFF_FFFF);
            size = $urandom_range(32'h0800_2000, 32'h7FFF_FFFF);
          end else begin
            case ($urandom_range(0, 4))
              0:       base = '0;
              1:       base = '1;
              2:       base = 32'hFFFF_F000;
              3:       base = 32'h8000_0000;
              default: base = $urandom;
            endcase
            case ($urandom_range(0, 4))
              0:       size = '0;
              1:       size = '1;
              2:       size = PageBytes;
              3:       size = PageMask;
              default: size = $urandom;
            endcase
          end
          len = $urandom_range(15, 50);
        end
        default: begin
          base = $urandom;
          size = $urandom_range(0, 100) * PageBytes + $urandom_range(0, PageMask);
          len  = $urandom_range(30, 110);
        end
      endcase
      configure(base, size);
      no_gaps = ($urandom_range(0, 3) == 0);
      alloc_share = $urandom_range(35, 65);
      issue(ModeInit, $urandom);
      repeat (len) random_word();
    end

    settle();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d commands (%0d allocate, %0d free, %0d init, %0d unused mode)",
             sent, n_alloc, n_free, n_init, n_other);
    $display("over %0d region settings; %0d results compared, %0d on an exhausted region.",
             region_count, checked, exhausted);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bitmap_page_allocator_top.sv
hw/rtl/bpa_checker.sv
bench/bpa_checker.sv
bench/testbench.sv
